FILE: sv/vre_pkg.sv
// ----------------------------------------------------------------------------
// vre_pkg
// Shared widths and the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package vre_pkg;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned RANK_W  = 6;

  typedef struct packed {
    logic load;     // store incoming value or flag overflow
    logic rd_key;   // read element i as the key
    logic clr;      // restart scan: j and rank to zero
    logic cap_key;  // capture key from read data
    logic scan;     // read element j, advance j
    logic emit;     // load output register
    logic next_i;   // advance to next element
    logic clr_set;  // set finished: clear count, overflow and i
  } vre_cmd_t;

  typedef struct packed {
    logic scan_last;  // element j being read is the final stored one
    logic res_last;   // element i is the final stored one
    logic out_free;   // output register can take a result
  } vre_sts_t;

endpackage

FILE: sv/vre_ctrl.sv
// ----------------------------------------------------------------------------
// vre_ctrl
// Sequencer: load, then per element key read, compare scan and result issue.
// ----------------------------------------------------------------------------
module vre_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              last_value_i,
  output logic              in_ready_o,
  input  vre_pkg::vre_sts_t sts_i,
  output vre_pkg::vre_cmd_t cmd_o
);
  import vre_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_KEY   = 3'd1;
  localparam logic [2:0] S_KEYW  = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_DRAIN = 3'd4;
  localparam logic [2:0] S_EMIT  = 3'd5;

  logic [2:0] state_q, state_d;
  vre_cmd_t   cmd;

  assign in_ready_o = (state_q == S_IDLE);
  assign cmd_o      = cmd;

  always_comb begin
    state_d = state_q;
    cmd     = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd.load = 1'b1;
          if (last_value_i) begin
            state_d = S_KEY;
          end
        end
      end
      S_KEY: begin
        cmd.rd_key = 1'b1;
        cmd.clr    = 1'b1;
        state_d    = S_KEYW;
      end
      S_KEYW: begin
        cmd.cap_key = 1'b1;
        cmd.scan    = 1'b1;
        state_d     = sts_i.scan_last ? S_DRAIN : S_SCAN;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts_i.scan_last) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd.emit = 1'b1;
          if (sts_i.res_last) begin
            cmd.clr_set = 1'b1;
            state_d     = S_IDLE;
          end else begin
            cmd.next_i = 1'b1;
            state_d    = S_KEY;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_load_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load |-> in_ready_o)
    else $error("load outside idle");
  a_scan_follows_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.cap_key |-> $past(cmd.rd_key))
    else $error("key capture without key read");
  a_emit_then_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.next_i |=> cmd.rd_key)
    else $error("next element not started");
`endif

endmodule

FILE: sv/vre_datapath.sv
// ----------------------------------------------------------------------------
// vre_datapath
// Value memory, fill count, key and scan pointers, rank counter, output register.
// ----------------------------------------------------------------------------
module vre_datapath #(
  parameter int unsigned MAX_ITEMS = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  vre_pkg::vre_cmd_t                   cmd_i,
  output vre_pkg::vre_sts_t                   sts_o,
  input  logic signed [vre_pkg::VALUE_W-1:0]  value_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [vre_pkg::RANK_W-1:0]          rank_o,
  output logic                                last_rank_o,
  output logic                                overflowed_o
);
  import vre_pkg::*;

  localparam int unsigned AW = $clog2(MAX_ITEMS);
  localparam int unsigned CW = $clog2(MAX_ITEMS + 1);

  logic signed [VALUE_W-1:0] mem [MAX_ITEMS];
  logic signed [VALUE_W-1:0] rd_data_q;
  logic signed [VALUE_W-1:0] key_q;
  logic [AW-1:0]             rd_addr;
  logic [CW-1:0]             count_q;
  logic                      ovf_q;
  logic [AW-1:0]             i_q;
  logic [AW-1:0]             j_q;
  logic [AW-1:0]             rank_q;
  logic                      cmp_vld_q;
  logic [AW-1:0]             top_idx;
  logic                      full;

  logic                      out_vld_q;
  logic [RANK_W-1:0]         out_rank_q;
  logic                      out_last_q;
  logic                      out_ovf_q;

  assign full    = (count_q == CW'(MAX_ITEMS));
  assign top_idx = AW'(count_q - CW'(1));
  assign rd_addr = cmd_i.rd_key ? i_q : j_q;

  assign sts_o.scan_last = (j_q == top_idx);
  assign sts_o.res_last  = (i_q == top_idx);
  assign sts_o.out_free  = !out_vld_q || out_ready_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && !full) begin
      mem[count_q[AW-1:0]] <= value_i;
    end
    rd_data_q <= mem[rd_addr];
    if (cmd_i.cap_key) begin
      key_q <= rd_data_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      ovf_q     <= 1'b0;
      i_q       <= '0;
      j_q       <= '0;
      rank_q    <= '0;
      cmp_vld_q <= 1'b0;
    end else begin
      if (cmd_i.clr_set) begin
        count_q <= '0;
        ovf_q   <= 1'b0;
        i_q     <= '0;
      end else begin
        if (cmd_i.load) begin
          if (full) begin
            ovf_q <= 1'b1;
          end else begin
            count_q <= count_q + CW'(1);
          end
        end
        if (cmd_i.next_i) begin
          i_q <= i_q + AW'(1);
        end
      end
      cmp_vld_q <= cmd_i.scan;
      if (cmd_i.clr) begin
        j_q    <= '0;
        rank_q <= '0;
      end else begin
        if (cmd_i.scan) begin
          j_q <= j_q + AW'(1);
        end
        if (cmp_vld_q && (rd_data_q < key_q)) begin
          rank_q <= rank_q + AW'(1);
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_rank_q <= RANK_W'(rank_q);
      out_last_q <= sts_o.res_last;
      out_ovf_q  <= ovf_q;
    end
  end

  assign out_valid_o  = out_vld_q;
  assign rank_o       = out_rank_q;
  assign last_rank_o  = out_last_q;
  assign overflowed_o = out_ovf_q;

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_ITEMS))
    else $error("fill count beyond capacity");
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> sts_o.out_free)
    else $error("result issued over a pending one");
  a_rank_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> (CW'(rank_q) < count_q))
    else $error("rank not below element count");
  a_set_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.clr_set |=> (count_q == '0) && !ovf_q)
    else $error("set not cleared after final result");
`endif

endmodule

FILE: sv/value_rank_engine_core.sv
// ----------------------------------------------------------------------------
// value_rank_engine_core
// Ranks a set of signed values by counting smaller values, results in load order.
// ----------------------------------------------------------------------------
// Values load at one request per cycle while idle. On the request marked last,
// each stored element i in turn is read as the key and compared against all n
// stored elements through the single read port of the value memory; each result
// takes a key read, n scan reads, a drain and an issue step, and the whole set
// is ranked before the next set is accepted. Values beyond MAX_ITEMS are dropped
// and flagged on every result of that set.
module value_rank_engine_core #(
  parameter int unsigned MAX_ITEMS = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [vre_pkg::VALUE_W-1:0]  value_i,
  input  logic                                last_value_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [vre_pkg::RANK_W-1:0]          rank_o,
  output logic                                last_rank_o,
  output logic                                overflowed_o
);
  import vre_pkg::*;

  vre_cmd_t cmd;
  vre_sts_t sts;

  vre_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .last_value_i (last_value_i),
    .in_ready_o   (in_ready_o),
    .sts_i        (sts),
    .cmd_o        (cmd)
  );

  vre_datapath #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .value_i      (value_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .rank_o       (rank_o),
    .last_rank_o  (last_rank_o),
    .overflowed_o (overflowed_o)
  );

endmodule

FILE: tb/value_rank_engine_core_test.sv
// ----------------------------------------------------------------------------
// value_rank_engine_core_test
// Self-checking bench for the counting-comparison rank engine.
// ----------------------------------------------------------------------------
// Sets of signed values are loaded over the request channel. Each set ends on
// the request marked last. A running model ranks every set the same way and
// queues the expected results, which are checked in load order. A short table
// of directed sets comes first, then a full set, an overflowing set and random
// sets, with random stalls on both channels.
`timescale 1ns / 100ps

module value_rank_engine_core_test;
  import vre_pkg::*;

  localparam int unsigned CAP          = 64;
  localparam int unsigned NUM_DIRECTED = 16;
  localparam int unsigned RANDOM_ITEMS = 124;
  localparam int unsigned RX_HOLD      = 600;

  typedef struct packed {
    logic [RANK_W-1:0] rank;
    logic              is_last;
    logic              ovf;
  } rank_res_t;

  // pin: typed-in rank, or negative to take the model's rank
  typedef struct packed {
    logic [VALUE_W-1:0] val;
    logic               is_last;
    logic signed [7:0]  pin;
  } stim_row_t;

  logic                      clk_i;
  logic                      rst_ni;
  logic                      in_valid_i;
  logic                      in_ready_o;
  logic signed [VALUE_W-1:0] value_i;
  logic                      last_value_i;
  logic                      out_valid_o;
  logic                      out_ready_i;
  logic [RANK_W-1:0]         rank_o;
  logic                      last_rank_o;
  logic                      overflowed_o;

  logic signed [7:0]         pin_rank;
  bit                        calm;
  bit                        rx_hold_req;

  logic signed [VALUE_W-1:0] held_vals [CAP];
  logic signed [7:0]         held_pins [CAP];
  int unsigned               held_n;
  bit                        dropped;
  rank_res_t                 rank_q [$];

  int unsigned               errors;
  int unsigned               values_in;
  int unsigned               ranks_seen;
  int unsigned               sets_done;
  int unsigned               ovf_sets;

  stim_row_t directed_rows [NUM_DIRECTED] = '{
    '{32'h0000_0000, 1'b1,  8'sd0},
    '{32'h8000_0000, 1'b0,  8'sd0},
    '{32'h7FFF_FFFF, 1'b0,  8'sd4},
    '{32'h0000_0000, 1'b0,  8'sd2},
    '{32'hFFFF_FFFF, 1'b0,  8'sd1},
    '{32'h0000_0001, 1'b1,  8'sd3},
    '{32'h0000_0007, 1'b0,  8'sd0},
    '{32'h0000_0007, 1'b0,  8'sd0},
    '{32'h0000_0007, 1'b1,  8'sd0},
    '{32'h0000_0005, 1'b0,  8'sd1},
    '{32'h0000_0005, 1'b0,  8'sd1},
    '{32'hFFFF_FFFB, 1'b1,  8'sd0},
    '{32'h5555_5555, 1'b0, -8'sd1},
    '{32'hAAAA_AAAA, 1'b0, -8'sd1},
    '{32'h0000_FFFF, 1'b0, -8'sd1},
    '{32'hFFFF_0000, 1'b1, -8'sd1}
  };

  value_rank_engine_core #(
    .MAX_ITEMS(CAP)
  ) u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .value_i     (value_i),
    .last_value_i(last_value_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .rank_o      (rank_o),
    .last_rank_o (last_rank_o),
    .overflowed_o(overflowed_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // store a value; on the last request rank the set in load order
  function automatic void load_and_rank(logic signed [VALUE_W-1:0] v, logic is_last,
                                        logic signed [7:0] pin);
    int unsigned smaller;
    rank_res_t   res;
    if (held_n < CAP) begin
      held_vals[held_n] = v;
      held_pins[held_n] = pin;
      held_n++;
    end else begin
      dropped = 1'b1;
    end
    if (is_last) begin
      for (int unsigned i = 0; i < held_n; i++) begin
        smaller = 0;
        for (int unsigned j = 0; j < held_n; j++) begin
          if (held_vals[j] < held_vals[i]) smaller++;
        end
        res.rank    = (held_pins[i] >= 0) ? held_pins[i][RANK_W-1:0] : smaller[RANK_W-1:0];
        res.is_last = (i + 1 == held_n);
        res.ovf     = dropped;
        rank_q.push_back(res);
      end
      sets_done++;
      if (dropped) ovf_sets++;
      held_n  = 0;
      dropped = 1'b0;
    end
  endfunction

  always @(posedge clk_i) begin
    rank_res_t want;
    if (rst_ni && in_valid_i && in_ready_o) begin
      values_in++;
      load_and_rank(value_i, last_value_i, pin_rank);
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      ranks_seen++;
      if (rank_q.size() == 0) begin
        $error("rank result with none pending: rank=%0d", rank_o);
        errors++;
      end else begin
        want = rank_q.pop_front();
        if (rank_o !== want.rank) begin
          $error("rank: expected %0d, got %0d", want.rank, rank_o);
          errors++;
        end
        if (last_rank_o !== want.is_last) begin
          $error("last_rank: expected %0d, got %0d", want.is_last, last_rank_o);
          errors++;
        end
        if (overflowed_o !== want.ovf) begin
          $error("overflowed: expected %0d, got %0d", want.ovf, overflowed_o);
          errors++;
        end
      end
    end
  end

  // result side: random stall bursts, plus one long hold on request
  initial begin
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (rx_hold_req) begin
        out_ready_i <= 1'b0;
        repeat (RX_HOLD) @(negedge clk_i);
        rx_hold_req = 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 18)) @(negedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
        @(negedge clk_i);
      end
    end
  end

  // called at a falling edge, returns at a falling edge after acceptance
  task automatic offer(logic [VALUE_W-1:0] v, logic is_last, logic signed [7:0] pin);
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    value_i      <= v;
    last_value_i <= is_last;
    pin_rank     <= pin;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  task automatic wait_for_ranks(int unsigned tail);
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (rank_q.size() != 0);
    repeat (tail) @(negedge clk_i);
  endtask

  function automatic logic [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 5))
      0, 1:    return $urandom;
      2, 3:    return VALUE_W'($urandom_range(0, 8) - 4);
      4: begin
        case ($urandom_range(0, 3))
          0:       return 32'h8000_0000;
          1:       return 32'h7FFF_FFFF;
          2:       return 32'h0000_0000;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      default: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
    endcase
  endfunction

  initial begin
    int unsigned sent;
    int unsigned set_len;
    in_valid_i   = 1'b0;
    value_i      = '0;
    last_value_i = 1'b0;
    pin_rank     = -8'sd1;
    calm         = 1'b0;
    rx_hold_req  = 1'b0;
    held_n       = 0;
    dropped      = 1'b0;
    errors       = 0;
    values_in    = 0;
    ranks_seen   = 0;
    sets_done    = 0;
    ovf_sets     = 0;
    rst_ni       = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[k]) begin
      offer(directed_rows[k].val, directed_rows[k].is_last, directed_rows[k].pin);
    end
    wait_for_ranks(8);

    // full store, strictly descending so the first rank is the top one
    for (int unsigned k = 0; k < CAP; k++) begin
      offer(VALUE_W'(2000 - 29 * int'(k)), k == CAP - 1, -8'sd1);
    end
    // past capacity, last mark on a dropped value
    for (int unsigned k = 0; k < CAP + 2; k++) begin
      offer(pick_value(), k == CAP + 1, -8'sd1);
    end

    rx_hold_req = 1'b1;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      set_len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
      if (RANDOM_ITEMS - sent > 30 && RANDOM_ITEMS - sent - set_len <= 30) calm = 1'b1;
      for (int unsigned k = 0; k < set_len; k++) begin
        offer(pick_value(), k == set_len - 1, -8'sd1);
      end
      sent += set_len;
    end
    wait_for_ranks(80);

    $display("%0d values loaded in %0d sets (%0d past capacity), %0d ranks checked",
             values_in, sets_done, ovf_sets, ranks_seen);
    if (errors == 0 && rank_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
